[rtl/emirp_checker_defines.svh]
`ifndef EMIRP_CHECKER_DEFINES_SVH
`define EMIRP_CHECKER_DEFINES_SVH

// checked on every clock edge outside reset
`define EMIRP_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// checked on every clock edge, reset included
`define EMIRP_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

[rtl/emirp_pkg.sv]
`default_nettype none

package emirp_pkg;

   localparam int VALUE_W       = 14;
   localparam int RADIX         = 10;
   localparam int FIRST_DIVISOR = 2;

   typedef logic [VALUE_W-1:0] value_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_REDUCE,
      S_REDUCE_WAIT,
      S_REV,
      S_REV_WAIT,
      S_PRIME_INIT,
      S_PRIME_CHECK,
      S_PRIME_WAIT,
      S_DONE
   } state_type;

endpackage

`default_nettype wire

[rtl/emirp_req_if.sv]
`default_nettype none

interface emirp_req_if
   import emirp_pkg::*;
;
   logic      valid;
   logic      ready;
   value_type value;

   modport source (output valid, output value, input ready);
   modport sink   (input valid, input value, output ready);
endinterface

`default_nettype wire

[rtl/emirp_rsp_if.sv]
`default_nettype none

interface emirp_rsp_if
   import emirp_pkg::*;
;
   logic      valid;
   logic      ready;
   value_type reversed_value;
   logic      value_prime;
   logic      reverse_prime;
   logic      both_prime;

   modport source (
      output valid, output reversed_value, output value_prime,
      output reverse_prime, output both_prime, input ready
   );
   modport sink (
      input valid, input reversed_value, input value_prime,
      input reverse_prime, input both_prime, output ready
   );
endinterface

`default_nettype wire

[rtl/emirp_div.sv]
`default_nettype none
`include "emirp_checker_defines.svh"

module emirp_div
   import emirp_pkg::*;
#(
   parameter int WIDTH = 14
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [WIDTH-1:0]   dividend,
   input  logic [WIDTH-1:0]   divisor,
   output div_status_type     status,
   output logic [WIDTH-1:0]   remainder
);

   localparam int CNT_W = $clog2(WIDTH + 1);

   logic [WIDTH-1:0] quo_ff;
   logic [WIDTH-1:0] rem_ff;
   logic [WIDTH-1:0] den_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic             busy_ff;
   logic             done_ff;

   logic [WIDTH:0]   shifted;
   logic [WIDTH:0]   diff;
   logic             fits;

   // restoring division, one quotient bit per cycle
   assign shifted = {rem_ff, quo_ff[WIDTH-1]};
   assign fits    = shifted >= {1'b0, den_ff};
   assign diff    = shifted - {1'b0, den_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            quo_ff  <= dividend;
            rem_ff  <= '0;
            den_ff  <= divisor;
            cnt_ff  <= CNT_W'(WIDTH);
         end else if (busy_ff) begin
            quo_ff <= {quo_ff[WIDTH-2:0], fits};
            rem_ff <= fits ? diff[WIDTH-1:0] : shifted[WIDTH-1:0];
            cnt_ff <= cnt_ff - CNT_W'(1);
            if (cnt_ff == CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign remainder   = rem_ff;

   `EMIRP_ASSERT(a_start_runs, start |=> busy_ff, "divider did not start")
   `EMIRP_ASSERT(a_rem_below_den, done_ff |-> (rem_ff < den_ff), "remainder not below divisor")
   `EMIRP_ASSERT(a_busy_count, busy_ff |-> (cnt_ff != '0), "divider busy with empty count")
   `EMIRP_ASSERT_ALWAYS(a_reset_idle, reset |=> (!busy_ff && !done_ff), "divider busy after reset")

endmodule

`default_nettype wire

[rtl/emirp_checker.sv]
// the value is reduced, then reversed digit by digit; each number, value then reverse, is
// not prime below 2, else tried by division from 2 while d*d <= n, each trial a serial
// divide with start and done
// throughput: one item at a time, the next is taken once the result is registered
// reset: synchronous, clears the sequencer and the result valid, no clearing pass
`default_nettype none
`include "emirp_checker_defines.svh"

module emirp_checker
   import emirp_pkg::*;
#(
   parameter int DIGITS = 4
) (
   input  logic        clock,
   input  logic        reset,
   emirp_req_if.sink   req_ch,
   emirp_rsp_if.source rsp_ch
);

   localparam int unsigned POW = RADIX ** DIGITS;
   localparam int POW_W = $clog2(POW + 1);
   localparam int NUM_W = (POW_W > VALUE_W) ? POW_W : VALUE_W;
   localparam int CNT_W = $clog2(DIGITS + 1);
   localparam int CHK_W = 2 * NUM_W + 1;

   // reciprocals: (n * M) >> S equals n / d for every n of the operand width
   localparam int RED_S = VALUE_W + $clog2(POW);
   localparam longint unsigned RED_M = ((64'd1 << RED_S) / 64'(POW)) + 64'd1;
   localparam int RED_P_W = VALUE_W + 16;
   localparam int DIG_S = NUM_W + $clog2(RADIX);
   localparam longint unsigned DIG_M = ((64'd1 << DIG_S) / 64'(RADIX)) + 64'd1;
   localparam int DIG_P_W = 2 * NUM_W + 1;

   state_type        state_ff;
   state_type        state_in;

   value_type        value_ff;
   value_type        red_q_ff;
   logic [NUM_W-1:0] ten_q_ff;
   logic [NUM_W-1:0] num_ff;
   logic [NUM_W-1:0] work_ff;
   logic [NUM_W-1:0] rev_ff;
   logic [NUM_W-1:0] d_ff;
   logic [NUM_W:0]   sq_ff;
   logic [CNT_W-1:0] dig_ff;
   logic             sel_ff;
   logic             vp_ff;
   logic             rp_ff;

   logic             rsp_valid_ff;
   value_type        rev_out_ff;
   logic             vp_out_ff;
   logic             rp_out_ff;
   logic             both_out_ff;

   div_status_type   div_st;
   logic             div_start;
   logic [NUM_W-1:0] div_rem;

   logic [RED_P_W-1:0] red_prod;
   value_type          red_quo;
   logic [NUM_W-1:0]   red_rem;
   logic [DIG_P_W-1:0] dig_prod;
   logic [NUM_W-1:0]   dig_quo;
   logic [NUM_W-1:0]   dig_rem;

   logic [NUM_W-1:0] cand;
   logic             cand_small;
   logic             sq_above;
   logic [NUM_W-1:0] rev_next;
   logic             rev_last;
   logic             rem_zero;
   logic             rsp_free;
   logic             rec_en;
   logic             rec_prime;
   logic             out_load;
   logic             accept;

   emirp_div #(
      .WIDTH (NUM_W)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (cand),
      .divisor   (d_ff),
      .status    (div_st),
      .remainder (div_rem)
   );

   // value modulo 10^DIGITS, quotient registered first
   assign red_prod   = RED_P_W'(value_ff) * RED_P_W'(RED_M);
   assign red_quo    = VALUE_W'(red_prod >> RED_S);
   assign red_rem    = NUM_W'(value_ff) - NUM_W'(red_q_ff * POW);

   // low digit split off, quotient registered first
   assign dig_prod   = DIG_P_W'(work_ff) * DIG_P_W'(DIG_M);
   assign dig_quo    = NUM_W'(dig_prod >> DIG_S);
   assign dig_rem    = work_ff - NUM_W'(ten_q_ff * RADIX);

   assign cand       = sel_ff ? rev_ff : num_ff;
   assign cand_small = cand < NUM_W'(FIRST_DIVISOR);
   assign sq_above   = sq_ff > {1'b0, cand};
   assign rem_zero   = div_rem == '0;
   // rev * 10 + digit as two shifted adds
   assign rev_next   = NUM_W'({rev_ff, 3'b000} + {2'b00, rev_ff, 1'b0}
                              + (NUM_W + 3)'(dig_rem));
   assign rev_last   = (ten_q_ff == '0) || (dig_ff == CNT_W'(DIGITS - 1));
   assign rsp_free   = !rsp_valid_ff || rsp_ch.ready;
   assign accept     = req_ch.valid && req_ch.ready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:        if (req_ch.valid) state_in = S_REDUCE;
         S_REDUCE:      state_in = S_REDUCE_WAIT;
         S_REDUCE_WAIT: state_in = S_REV;
         S_REV:         state_in = S_REV_WAIT;
         S_REV_WAIT:    state_in = rev_last ? S_PRIME_INIT : S_REV;
         S_PRIME_INIT: begin
            if (cand_small) state_in = sel_ff ? S_DONE : S_PRIME_INIT;
            else            state_in = S_PRIME_CHECK;
         end
         S_PRIME_CHECK: begin
            if (sq_above) state_in = sel_ff ? S_DONE : S_PRIME_INIT;
            else          state_in = S_PRIME_WAIT;
         end
         S_PRIME_WAIT: begin
            if (div_st.done) begin
               if (rem_zero) state_in = sel_ff ? S_DONE : S_PRIME_INIT;
               else          state_in = S_PRIME_CHECK;
            end
         end
         S_DONE:        if (rsp_free) state_in = S_IDLE;
         default:       state_in = S_IDLE;
      endcase
   end

   always_comb begin
      req_ch.ready = 1'b0;
      div_start    = 1'b0;
      rec_en       = 1'b0;
      rec_prime    = 1'b0;
      out_load     = 1'b0;
      unique case (state_ff)
         S_IDLE: req_ch.ready = 1'b1;
         S_PRIME_INIT: begin
            rec_en    = cand_small;
            rec_prime = 1'b0;
         end
         S_PRIME_CHECK: begin
            // past the square root with no divisor found
            div_start = !sq_above;
            rec_en    = sq_above;
            rec_prime = 1'b1;
         end
         S_PRIME_WAIT: begin
            rec_en    = div_st.done && rem_zero;
            rec_prime = 1'b0;
         end
         S_DONE: out_load = rsp_free;
         S_REDUCE, S_REDUCE_WAIT, S_REV, S_REV_WAIT: ;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;

         if (accept) value_ff <= req_ch.value;

         if (state_ff == S_REDUCE) red_q_ff <= red_quo;

         if (state_ff == S_REDUCE_WAIT) begin
            num_ff  <= red_rem;
            work_ff <= red_rem;
            rev_ff  <= '0;
            dig_ff  <= '0;
            sel_ff  <= 1'b0;
         end

         if (state_ff == S_REV) ten_q_ff <= dig_quo;

         if (state_ff == S_REV_WAIT) begin
            rev_ff  <= rev_next;
            work_ff <= ten_q_ff;
            dig_ff  <= dig_ff + CNT_W'(1);
         end

         if (state_ff == S_PRIME_INIT) begin
            d_ff  <= NUM_W'(FIRST_DIVISOR);
            sq_ff <= (NUM_W + 1)'(FIRST_DIVISOR * FIRST_DIVISOR);
         end

         // next divisor, square kept by adding 2d + 1
         if (state_ff == S_PRIME_WAIT && div_st.done && !rem_zero) begin
            d_ff  <= d_ff + NUM_W'(1);
            sq_ff <= sq_ff + {d_ff, 1'b1};
         end

         if (rec_en) begin
            if (sel_ff) rp_ff <= rec_prime;
            else        vp_ff <= rec_prime;
            sel_ff <= 1'b1;
         end

         if (out_load) begin
            rsp_valid_ff <= 1'b1;
            rev_out_ff   <= rev_ff[VALUE_W-1:0];
            vp_out_ff    <= vp_ff;
            rp_out_ff    <= rp_ff;
            both_out_ff  <= vp_ff && rp_ff;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.reversed_value = rev_out_ff;
   assign rsp_ch.value_prime    = vp_out_ff;
   assign rsp_ch.reverse_prime  = rp_out_ff;
   assign rsp_ch.both_prime     = both_out_ff;

   `EMIRP_ASSERT(a_both_flag, rsp_valid_ff |-> (both_out_ff == (vp_out_ff && rp_out_ff)), "both flag mismatch")
   `EMIRP_ASSERT(a_square_track, (state_ff == S_PRIME_CHECK) |-> (CHK_W'(sq_ff) == CHK_W'(d_ff) * CHK_W'(d_ff)), "square out of step with divisor")
   `EMIRP_ASSERT(a_div_free, div_start |-> !div_st.busy, "divider started while busy")
   `EMIRP_ASSERT_ALWAYS(a_reset_clear, reset |=> (!rsp_valid_ff && (state_ff == S_IDLE)), "not idle after reset")

endmodule

`default_nettype wire

[test/emirp_checker_tb.sv]
`timescale 1ns / 100ps

module emirp_checker_tb;
   import emirp_pkg::*;

   localparam int DIGITS = 4;
   localparam int RANDOM_ITEMS = 400;
   localparam int DRAIN_CYCLES = 4000;
   localparam int IDLE_PERCENT = 15;

   typedef struct packed {
      value_type reversed_value;
      logic      value_prime;
      logic      reverse_prime;
      logic      both_prime;
   } emirp_result_type;

   // typed_in marks rows whose result is written out by hand
   typedef struct packed {
      value_type        value;
      logic             typed_in;
      emirp_result_type result;
   } emirp_vector_type;

   localparam int N_VECTORS = 23;

   emirp_vector_type directed_vectors [N_VECTORS] = '{
      '{14'd0,     1'b1, '{14'd0,    1'b0, 1'b0, 1'b0}},
      '{14'd1,     1'b1, '{14'd1,    1'b0, 1'b0, 1'b0}},
      '{14'd2,     1'b1, '{14'd2,    1'b1, 1'b1, 1'b1}},
      '{14'd3,     1'b1, '{14'd3,    1'b1, 1'b1, 1'b1}},
      '{14'd4,     1'b1, '{14'd4,    1'b0, 1'b0, 1'b0}},
      '{14'd10,    1'b1, '{14'd1,    1'b0, 1'b0, 1'b0}},
      '{14'd13,    1'b1, '{14'd31,   1'b1, 1'b1, 1'b1}},
      '{14'd1000,  1'b1, '{14'd1,    1'b0, 1'b0, 1'b0}},
      '{14'd9999,  1'b1, '{14'd9999, 1'b0, 1'b0, 1'b0}},
      '{14'd10000, 1'b1, '{14'd0,    1'b0, 1'b0, 1'b0}},
      '{14'd10007, 1'b1, '{14'd7,    1'b1, 1'b1, 1'b1}},
      '{14'd23,    1'b0, '0},
      '{14'd120,   1'b0, '0},
      '{14'd97,    1'b0, '0},
      '{14'd49,    1'b0, '0},
      '{14'd121,   1'b0, '0},
      '{14'd1009,  1'b0, '0},
      '{14'd5000,  1'b0, '0},
      '{14'd8191,  1'b0, '0},
      '{14'd9409,  1'b0, '0},
      '{14'd9973,  1'b0, '0},
      '{14'd12345, 1'b0, '0},
      '{14'd16383, 1'b0, '0}
   };

   logic clock;
   logic reset;

   emirp_req_if req_if ();
   emirp_rsp_if rsp_if ();

   emirp_checker #(.DIGITS(DIGITS)) DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_if),
      .rsp_ch (rsp_if)
   );

   emirp_result_type pending_results [$];
   int               failures;
   bit               calm;

   function automatic bit is_prime_number(int unsigned n);
      int unsigned d;
      if (n < FIRST_DIVISOR)
         return 1'b0;
      for (d = FIRST_DIVISOR; d * d <= n; d++) begin
         if (n % d == 0)
            return 1'b0;
      end
      return 1'b1;
   endfunction

   function automatic emirp_result_type emirp_of(value_type raw);
      emirp_result_type res;
      int unsigned modulus;
      int unsigned v;
      int unsigned n;
      int unsigned r;
      modulus = 1;
      for (int i = 0; i < DIGITS; i++)
         modulus = modulus * RADIX;
      v = raw % modulus;
      n = v;
      r = 0;
      for (int i = 0; i < DIGITS; i++) begin
         r = r * RADIX + n % RADIX;
         n = n / RADIX;
         if (n == 0)
            break;
      end
      res.reversed_value = value_type'(r);
      res.value_prime    = is_prime_number(v);
      res.reverse_prime  = is_prime_number(r);
      res.both_prime     = res.value_prime && res.reverse_prime;
      return res;
   endfunction

   // mostly short numbers, a share of primes to run the full divisor sweep,
   // and a few above four digits
   function automatic value_type pick_value();
      int unsigned pick;
      int unsigned n;
      pick = $urandom_range(99);
      if (pick < 40)
         return value_type'($urandom_range(999));
      if (pick < 75)
         return value_type'($urandom_range(9999));
      if (pick < 95) begin
         n = $urandom_range(9999);
         while (!is_prime_number(n))
            n = (n + 1) % 10000;
         return value_type'(n);
      end
      return value_type'($urandom_range(16383, 10000));
   endfunction

   task automatic push_value(value_type v, emirp_result_type exp);
      req_if.valid <= 1'b1;
      req_if.value <= v;
      @(posedge clock);
      while (!req_if.ready)
         @(posedge clock);
      pending_results.push_back(exp);
      if (!calm && $urandom_range(99) < IDLE_PERCENT) begin
         req_if.valid <= 1'b0;
         req_if.value <= value_type'($urandom);
         do
            @(posedge clock);
         while ($urandom_range(99) < 50);
      end
   endtask

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      value_type v;
      reset        = 1'b1;
      req_if.valid = 1'b0;
      req_if.value = '0;
      rsp_if.ready = 1'b0;
      failures     = 0;
      calm         = 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_vectors[i]) begin
         if (directed_vectors[i].typed_in)
            push_value(directed_vectors[i].value, directed_vectors[i].result);
         else
            push_value(directed_vectors[i].value, emirp_of(directed_vectors[i].value));
      end

      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         // a long stretch with both sides always willing
         calm = (i >= 150 && i < 250);
         v = pick_value();
         push_value(v, emirp_of(v));
      end
      calm = 1'b0;
      req_if.valid <= 1'b0;

      while (pending_results.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (failures == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

   // result side: random back-pressure and checking of each transfer
   always @(posedge clock) begin
      emirp_result_type exp;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (pending_results.size() == 0) begin
            $error("result transfer with nothing expected, reversed_value %0d",
                   rsp_if.reversed_value);
            failures++;
         end else begin
            exp = pending_results.pop_front();
            if (rsp_if.reversed_value !== exp.reversed_value) begin
               $error("reversed_value: expected %0d, actual %0d",
                      exp.reversed_value, rsp_if.reversed_value);
               failures++;
            end
            if (rsp_if.value_prime !== exp.value_prime) begin
               $error("value_prime: expected %0b, actual %0b",
                      exp.value_prime, rsp_if.value_prime);
               failures++;
            end
            if (rsp_if.reverse_prime !== exp.reverse_prime) begin
               $error("reverse_prime: expected %0b, actual %0b",
                      exp.reverse_prime, rsp_if.reverse_prime);
               failures++;
            end
            if (rsp_if.both_prime !== exp.both_prime) begin
               $error("both_prime: expected %0b, actual %0b",
                      exp.both_prime, rsp_if.both_prime);
               failures++;
            end
         end
      end
      rsp_if.ready <= calm || ($urandom_range(99) >= IDLE_PERCENT);
   end

   // the limit covers the worst case for every item, taken several times over
   initial begin
      #60000000;
      $display("RESULT: ERROR");
      $finish;
   end

endmodule
